// ===== rtl/acm_pkg.sv =====
// Shared constants, codes and types of the Aho-Corasick matcher.
package acm_pkg;

    localparam int MAX_STATES = 1024;
    localparam int SYMBOLS    = 256;

    localparam int SW  = $clog2(MAX_STATES);
    localparam int BW  = $clog2(SYMBOLS);
    localparam int CW  = SW + 1;
    localparam int TAW = SW + BW;

    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MATCH  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    localparam logic [BW-1:0] SYM_LAST  = BW'(SYMBOLS - 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_STATES);

    typedef struct packed {
        logic [SW-1:0] q;
        logic [SW-1:0] fail;
        logic          endm;
        logic          hitm;
    } node_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [BW-1:0]    sym;
        logic             last;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                here;
        logic                seen;
        logic                done;
    } res_t;

endpackage

// ===== rtl/acm_if.sv =====
// Request and result channel interfaces of the Aho-Corasick matcher.
interface acm_item_if;
    import acm_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    modport source (output valid, output cmd, output data_byte, output last, input ready);
    modport sink (input valid, input cmd, input data_byte, input last, output ready);
endinterface

interface acm_result_if;
    import acm_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                hit_here;
    logic                hit_seen;
    logic                text_done;
    modport source (output valid, output status, output hit_here, output hit_seen,
                    output text_done, input ready);
    modport sink (input valid, input status, input hit_here, input hit_seen,
                  input text_done, output ready);
endinterface

// ===== rtl/acm_engine.sv =====
// Table memories and command sequencer of the Aho-Corasick matcher.
module acm_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  acm_pkg::req_t req,
    output logic          idle,
    output logic          res_valid,
    input  logic          res_ready,
    output acm_pkg::res_t res
);
    import acm_pkg::*;

    localparam logic [4:0] ST_SWEEP   = 5'd0;
    localparam logic [4:0] ST_IDLE    = 5'd1;
    localparam logic [4:0] ST_I_CHK   = 5'd2;
    localparam logic [4:0] ST_I_END   = 5'd3;
    localparam logic [4:0] ST_BR_RD   = 5'd4;
    localparam logic [4:0] ST_BR_CHK  = 5'd5;
    localparam logic [4:0] ST_BR_WR   = 5'd6;
    localparam logic [4:0] ST_BR_Q    = 5'd7;
    localparam logic [4:0] ST_B_POP   = 5'd8;
    localparam logic [4:0] ST_B_PQ    = 5'd9;
    localparam logic [4:0] ST_B_PF    = 5'd10;
    localparam logic [4:0] ST_BC_RD   = 5'd11;
    localparam logic [4:0] ST_BC_CHK  = 5'd12;
    localparam logic [4:0] ST_CH_CHK  = 5'd13;
    localparam logic [4:0] ST_CH_FAIL = 5'd14;
    localparam logic [4:0] ST_M_HIT   = 5'd15;
    localparam logic [4:0] ST_B_HF    = 5'd16;
    localparam logic [4:0] ST_B_EC    = 5'd17;
    localparam logic [4:0] ST_DONE    = 5'd18;

    logic [SW-1:0] trans_mem [2**TAW];
    node_t         node_mem  [2**SW];

    logic [SW-1:0]  t_rdata_reg;
    node_t          n_rdata_reg;
    logic [TAW-1:0] t_raddr, t_waddr;
    logic           t_we;
    logic [SW-1:0]  t_wdata;
    logic [SW-1:0]  n_raddr, n_waddr;
    logic           n_we_q, n_we_node;
    node_t          n_wdata;

    logic [4:0]       state_reg, state_next;
    logic [TAW-1:0]   sweep_reg, sweep_next;
    logic             reply_reg, reply_next;
    logic [CW-1:0]    used_reg, used_next;
    logic [SW-1:0]    cursor_reg, cursor_next;
    logic             drop_reg, drop_next;
    logic [SW-1:0]    match_reg, match_next;
    logic             found_reg, found_next;
    logic [CW-1:0]    head_reg, head_next;
    logic [CW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    steps_reg, steps_next;

    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [BW-1:0]    b_reg, b_next;
    logic             last_reg, last_next;
    logic [SW-1:0]    s_reg, s_next;
    logic [SW-1:0]    cc_reg, cc_next;
    logic [SW-1:0]    fc_reg, fc_next;
    logic [SW-1:0]    p_reg, p_next;
    logic [SW-1:0]    fp_reg, fp_next;
    logic             hitf_reg, hitf_next;
    res_t             res_reg, res_next;

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            trans_mem[t_waddr] <= t_wdata;
        end
        t_rdata_reg <= trans_mem[t_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (n_we_q)
        begin
            node_mem[n_waddr].q <= n_wdata.q;
        end
        if (n_we_node)
        begin
            node_mem[n_waddr].fail <= n_wdata.fail;
            node_mem[n_waddr].endm <= n_wdata.endm;
            node_mem[n_waddr].hitm <= n_wdata.hitm;
        end
        n_rdata_reg <= node_mem[n_raddr];
    end

    always_comb
    begin
        logic [SW-1:0] c;
        logic [SW-1:0] cn;
        logic          fn;
        c           = t_rdata_reg;
        cn          = '0;
        fn          = 1'b0;
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        reply_next  = reply_reg;
        used_next   = used_reg;
        cursor_next = cursor_reg;
        drop_next   = drop_reg;
        match_next  = match_reg;
        found_next  = found_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        steps_next  = steps_reg;
        cmd_next    = cmd_reg;
        b_next      = b_reg;
        last_next   = last_reg;
        s_next      = s_reg;
        cc_next     = cc_reg;
        fc_next     = fc_reg;
        p_next      = p_reg;
        fp_next     = fp_reg;
        hitf_next   = hitf_reg;
        res_next    = res_reg;
        t_raddr     = {s_reg, b_reg};
        t_we        = 1'b0;
        t_waddr     = {cursor_reg, b_reg};
        t_wdata     = '0;
        n_raddr     = s_reg;
        n_we_q      = 1'b0;
        n_we_node   = 1'b0;
        n_waddr     = cc_reg;
        n_wdata     = '0;
        idle        = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            ST_SWEEP:
            begin
                t_we       = 1'b1;
                t_waddr    = sweep_reg;
                n_we_q     = 1'b1;
                n_we_node  = 1'b1;
                n_waddr    = sweep_reg[TAW-1 -: SW];
                sweep_next = sweep_reg + 1'b1;
                if (&sweep_reg)
                begin
                    used_next   = CW'(1);
                    cursor_next = '0;
                    drop_next   = 1'b0;
                    match_next  = '0;
                    found_next  = 1'b0;
                    res_next    = '0;
                    state_next  = reply_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    cmd_next  = req.cmd;
                    b_next    = req.sym;
                    last_next = req.last;
                    res_next  = '0;
                    case (req.cmd)
                        CMD_CLEAR:
                        begin
                            sweep_next = '0;
                            reply_next = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        CMD_INSERT:
                        begin
                            if (drop_reg)
                            begin
                                res_next.status = STATUS_FULL;
                                if (req.last)
                                begin
                                    cursor_next = '0;
                                    drop_next   = 1'b0;
                                end
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                t_raddr    = {cursor_reg, req.sym};
                                state_next = ST_I_CHK;
                            end
                        end
                        CMD_BUILD:
                        begin
                            b_next     = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            state_next = ST_BR_RD;
                        end
                        default:
                        begin
                            s_next     = match_reg;
                            steps_next = '0;
                            t_raddr    = {match_reg, req.sym};
                            state_next = ST_CH_CHK;
                        end
                    endcase
                end
            end
            ST_I_CHK:
            begin
                if (c == '0 && used_reg >= MAX_COUNT)
                begin
                    res_next.status = STATUS_FULL;
                    drop_next       = 1'b1;
                    if (last_reg)
                    begin
                        cursor_next = '0;
                        drop_next   = 1'b0;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    cn = c;
                    if (c == '0)
                    begin
                        cn        = used_reg[SW-1:0];
                        used_next = used_reg + 1'b1;
                        t_we      = 1'b1;
                        t_waddr   = {cursor_reg, b_reg};
                        t_wdata   = cn;
                    end
                    cursor_next = cn;
                    cc_next     = cn;
                    n_raddr     = cn;
                    state_next  = last_reg ? ST_I_END : ST_DONE;
                end
            end
            ST_I_END:
            begin
                if (n_rdata_reg.endm)
                begin
                    res_next.status = STATUS_DUP;
                end
                else
                begin
                    n_we_node    = 1'b1;
                    n_waddr      = cc_reg;
                    n_wdata.fail = n_rdata_reg.fail;
                    n_wdata.endm = 1'b1;
                    n_wdata.hitm = 1'b1;
                end
                cursor_next = '0;
                drop_next   = 1'b0;
                state_next  = ST_DONE;
            end
            ST_BR_RD:
            begin
                t_raddr    = {{SW{1'b0}}, b_reg};
                state_next = ST_BR_CHK;
            end
            ST_BR_CHK:
            begin
                if (c != '0)
                begin
                    cc_next    = c;
                    n_raddr    = c;
                    state_next = ST_BR_WR;
                end
                else if (b_reg == SYM_LAST)
                begin
                    state_next = ST_B_POP;
                end
                else
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = ST_BR_RD;
                end
            end
            ST_BR_WR:
            begin
                n_we_node    = 1'b1;
                n_waddr      = cc_reg;
                n_wdata.endm = n_rdata_reg.endm;
                n_wdata.hitm = n_rdata_reg.endm;
                state_next   = ST_BR_Q;
            end
            ST_BR_Q:
            begin
                n_we_q    = 1'b1;
                n_waddr   = tail_reg[SW-1:0];
                n_wdata.q = cc_reg;
                tail_next = tail_reg + 1'b1;
                if (b_reg == SYM_LAST)
                begin
                    state_next = ST_B_POP;
                end
                else
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = ST_BR_RD;
                end
            end
            ST_B_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    match_next = '0;
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    n_raddr    = head_reg[SW-1:0];
                    head_next  = head_reg + 1'b1;
                    state_next = ST_B_PQ;
                end
            end
            ST_B_PQ:
            begin
                p_next     = n_rdata_reg.q;
                n_raddr    = n_rdata_reg.q;
                state_next = ST_B_PF;
            end
            ST_B_PF:
            begin
                fp_next    = n_rdata_reg.fail;
                b_next     = '0;
                state_next = ST_BC_RD;
            end
            ST_BC_RD:
            begin
                t_raddr    = {p_reg, b_reg};
                state_next = ST_BC_CHK;
            end
            ST_BC_CHK:
            begin
                if (c == '0)
                begin
                    if (b_reg == SYM_LAST)
                    begin
                        state_next = ST_B_POP;
                    end
                    else
                    begin
                        b_next     = b_reg + 1'b1;
                        state_next = ST_BC_RD;
                    end
                end
                else
                begin
                    cc_next    = c;
                    n_we_q     = 1'b1;
                    n_waddr    = tail_reg[SW-1:0];
                    n_wdata.q  = c;
                    tail_next  = tail_reg + 1'b1;
                    s_next     = fp_reg;
                    steps_next = '0;
                    t_raddr    = {fp_reg, b_reg};
                    state_next = ST_CH_CHK;
                end
            end
            ST_CH_CHK:
            begin
                if (c == '0 && s_reg != '0 && steps_reg < MAX_COUNT)
                begin
                    n_raddr    = s_reg;
                    state_next = ST_CH_FAIL;
                end
                else if (cmd_reg == CMD_MATCH)
                begin
                    cn         = (c != '0) ? c : s_reg;
                    s_next     = cn;
                    n_raddr    = cn;
                    state_next = ST_M_HIT;
                end
                else
                begin
                    cn         = (c != '0 && c != cc_reg) ? c : '0;
                    fc_next    = cn;
                    n_raddr    = cn;
                    state_next = ST_B_HF;
                end
            end
            ST_CH_FAIL:
            begin
                s_next     = n_rdata_reg.fail;
                steps_next = steps_reg + 1'b1;
                t_raddr    = {n_rdata_reg.fail, b_reg};
                state_next = ST_CH_CHK;
            end
            ST_M_HIT:
            begin
                fn            = found_reg | n_rdata_reg.hitm;
                res_next.here = n_rdata_reg.hitm;
                res_next.seen = fn;
                res_next.done = last_reg;
                if (last_reg)
                begin
                    match_next = '0;
                    found_next = 1'b0;
                end
                else
                begin
                    match_next = s_reg;
                    found_next = fn;
                end
                state_next = ST_DONE;
            end
            ST_B_HF:
            begin
                hitf_next  = n_rdata_reg.hitm;
                n_raddr    = cc_reg;
                state_next = ST_B_EC;
            end
            ST_B_EC:
            begin
                n_we_node    = 1'b1;
                n_waddr      = cc_reg;
                n_wdata.fail = fc_reg;
                n_wdata.endm = n_rdata_reg.endm;
                n_wdata.hitm = n_rdata_reg.endm | hitf_reg;
                if (b_reg == SYM_LAST)
                begin
                    state_next = ST_B_POP;
                end
                else
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = ST_BC_RD;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            sweep_reg  <= '0;
            reply_reg  <= 1'b0;
            used_reg   <= CW'(1);
            cursor_reg <= '0;
            drop_reg   <= 1'b0;
            match_reg  <= '0;
            found_reg  <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
            steps_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            reply_reg  <= reply_next;
            used_reg   <= used_next;
            cursor_reg <= cursor_next;
            drop_reg   <= drop_next;
            match_reg  <= match_next;
            found_reg  <= found_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            steps_reg  <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        b_reg    <= b_next;
        last_reg <= last_next;
        s_reg    <= s_next;
        cc_reg   <= cc_next;
        fc_reg   <= fc_next;
        p_reg    <= p_next;
        fp_reg   <= fp_next;
        hitf_reg <= hitf_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== rtl/aho_corasick_matcher_core.sv =====
// Aho-Corasick multi-pattern matcher: request channel, result register, table engine.
//
// Usage: every request on item (cmd, data_byte, last) yields exactly one response
// on result (status, hit_here, hit_seen, text_done), in order, valid/ready on both.
// Commands: clear, insert one pattern byte, build failure links, match one text byte.
// The engine takes no new request until it is done with the current one:
//   match follows failure links as needed, build visits every symbol of every
//   trie state and chases failure links, and clear sweeps the whole tables,
//   writing one transition entry and one state entry per cycle.
// Reads of the transition and state memories are registered, so each request runs
// as a chain of dependent reads; the result register sits in front of result.
// After reset the same clearing sweep runs and item.ready stays low until it ends.
// A result waiting in the output register does not block the next request; the
// engine holds a finished result only while that register is full and
// result.ready is low.
module aho_corasick_matcher_core (
    input logic           clk,
    input logic           rst_n,
    acm_item_if.sink      item,
    acm_result_if.source  result
);
    import acm_pkg::*;

    req_t req;
    res_t res;
    res_t out_res_reg;
    logic out_valid_reg, out_valid_next;
    logic idle, res_valid, res_ready, start;

    assign req.cmd  = item.cmd;
    assign req.sym  = item.data_byte[BW-1:0];
    assign req.last = item.last;

    assign item.ready = idle;
    assign start      = item.valid & idle;
    assign res_ready  = ~out_valid_reg | result.ready;

    acm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.status    = out_res_reg.status;
    assign result.hit_here  = out_res_reg.here;
    assign result.hit_seen  = out_res_reg.seen;
    assign result.text_done = out_res_reg.done;

endmodule
